// ===== src/lcai_pkg.sv =====
package lcai_pkg;

    localparam int LINE_CAPACITY = 32;
    localparam int LEN_W = $clog2(LINE_CAPACITY + 1);
    localparam int MAX_CHUNK = 64;
    localparam int CHUNK_W = 7;
    localparam int FIT_W = ((LEN_W > CHUNK_W) ? LEN_W : CHUNK_W) + 1;
    localparam int CFG_W = 16;
    localparam int CFG_INDEX_W = 2;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam logic [63:0] IDLE_WORD = {"<IDLE>", 16'h0000};
    localparam logic [63:0] ACTIVE_WORD = "<ACTIVE>";
    localparam logic [63:0] ALARM_WORD = {"<ALARM>", 8'h00};
    localparam logic [LEN_W-1:0] IDLE_LEN = LEN_W'(6);
    localparam logic [LEN_W-1:0] ACTIVE_LEN = LEN_W'(8);
    localparam logic [LEN_W-1:0] ALARM_LEN = LEN_W'(7);

    localparam logic [CFG_W-1:0] HEARTBEAT_TIMEOUT_RESET = 16'd2000;
    localparam logic [CFG_W-1:0] BLINK_PERIOD_RESET = 16'd1000;
    localparam logic [CFG_W-1:0] ALARM_PERIOD_RESET = 16'd250;

    typedef enum logic [1:0] {
        MODE_DISCONNECTED = 2'd0,
        MODE_IDLE         = 2'd1,
        MODE_ACTIVE       = 2'd2,
        MODE_ALARM        = 2'd3
    } mode_t;

    typedef enum logic [0:0] {
        CMD_BYTE = 1'b0,
        CMD_TICK = 1'b1
    } command_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HEARTBEAT_TIMEOUT = 2'd0,
        REG_BLINK_PERIOD      = 2'd1,
        REG_ALARM_PERIOD      = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic  green_on;
        logic  red_on;
        logic  buzzer_enable;
        mode_t mode_now;
    } result_t;

    // Character at position pos of a command word packed left-aligned.
    function automatic logic [7:0] word_byte(logic [63:0] word, logic [2:0] pos);
        logic [63:0] shifted;
        shifted = word << {pos, 3'b000};
        return shifted[63:56];
    endfunction

endpackage

// ===== src/line_command_alarm_indicator_core.sv =====
// A request's result is registered into the output buffer when the request is accepted.
// Throughput: one request per cycle while in_ready is high; all state updates are one pass of logic per request.
// A two-entry output buffer lets one further request in while the
// result side stalls; in_ready drops only when both entries are full.
// Reset (rst_n low, asynchronous) clears the line, the counters, the mode to
// disconnected, the output buffer, and loads the default register values.
module line_command_alarm_indicator_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                command,
    input  logic [7:0]                          rx_byte,
    input  logic                                chunk_first,
    input  logic [lcai_pkg::CHUNK_W-1:0]        chunk_len,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                green_on,
    output logic                                red_on,
    output logic                                buzzer_enable,
    output logic [1:0]                          mode_now,
    input  logic                                cfg_we,
    input  logic [lcai_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lcai_pkg::CFG_W-1:0]          cfg_data
);
    import lcai_pkg::*;

    logic [CFG_W-1:0] timeout_reg, timeout_next;
    logic [CFG_W-1:0] blink_period_reg, blink_period_next;
    logic [CFG_W-1:0] alarm_period_reg, alarm_period_next;

    logic [LEN_W-1:0]   line_length_reg, line_length_next;
    logic [CHUNK_W-1:0] skip_reg, skip_next;
    logic               cr_reg, cr_next;
    logic               m_idle_reg, m_idle_next;
    logic               m_active_reg, m_active_next;
    logic               m_alarm_reg, m_alarm_next;
    logic               pend_valid_reg, pend_valid_next;
    mode_t              pend_mode_reg, pend_mode_next;
    mode_t              mode_reg, mode_next;
    logic [15:0]        heartbeat_reg, heartbeat_next;
    logic [15:0]        blink_reg, blink_next;
    logic [15:0]        alarm_reg, alarm_next;

    logic               out_valid_reg, out_valid_next;
    logic               skid_valid_reg, skid_valid_next;
    result_t            out_reg, out_next;
    result_t            skid_reg, skid_next;

    logic               accept;
    logic               out_take;
    logic [CHUNK_W-1:0] clen;
    logic               take;
    logic [16:0]        blink_inc;
    logic [16:0]        alarm_inc;
    logic               blink_on;
    result_t            res;

    assign in_ready = !skid_valid_reg;
    assign accept = in_valid && in_ready;
    assign out_take = out_valid_reg && out_ready;
    assign clen = (chunk_len == '0) ? CHUNK_W'(1) : chunk_len;
    assign blink_inc = {1'b0, blink_reg} + 17'd1;
    assign alarm_inc = {1'b0, alarm_reg} + 17'd1;

    always_comb
    begin
        timeout_next = timeout_reg;
        blink_period_next = blink_period_reg;
        alarm_period_next = alarm_period_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HEARTBEAT_TIMEOUT: timeout_next = cfg_data;
                REG_BLINK_PERIOD:      blink_period_next = cfg_data;
                REG_ALARM_PERIOD:      alarm_period_next = cfg_data;
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        line_length_next = line_length_reg;
        skip_next = skip_reg;
        cr_next = cr_reg;
        m_idle_next = m_idle_reg;
        m_active_next = m_active_reg;
        m_alarm_next = m_alarm_reg;
        pend_valid_next = pend_valid_reg;
        pend_mode_next = pend_mode_reg;
        mode_next = mode_reg;
        heartbeat_next = heartbeat_reg;
        blink_next = blink_reg;
        alarm_next = alarm_reg;
        take = 1'b0;
        blink_on = 1'b0;
        res = '0;

        if (accept)
        begin
            if (command == CMD_BYTE)
            begin
                if (chunk_first)
                begin
                    if (FIT_W'(line_length_reg) + FIT_W'(clen) > FIT_W'(LINE_CAPACITY))
                    begin
                        line_length_next = '0;
                        cr_next = 1'b0;
                        m_idle_next = 1'b1;
                        m_active_next = 1'b1;
                        m_alarm_next = 1'b1;
                        skip_next = clen - CHUNK_W'(1);
                    end
                    else
                    begin
                        skip_next = '0;
                        take = 1'b1;
                    end
                end
                else if (skip_reg != '0)
                begin
                    skip_next = skip_reg - CHUNK_W'(1);
                end
                else
                begin
                    take = 1'b1;
                end

                if (take)
                begin
                    if (line_length_reg >= LEN_W'(LINE_CAPACITY))
                    begin
                        line_length_next = '0;
                        cr_next = 1'b0;
                        m_idle_next = 1'b1;
                        m_active_next = 1'b1;
                        m_alarm_next = 1'b1;
                    end
                    else if (cr_reg && rx_byte == CHAR_LF)
                    begin
                        if (pend_valid_reg)
                        begin
                            mode_next = pend_mode_reg;
                        end
                        heartbeat_next = '0;
                        line_length_next = '0;
                        cr_next = 1'b0;
                        m_idle_next = 1'b1;
                        m_active_next = 1'b1;
                        m_alarm_next = 1'b1;
                    end
                    else
                    begin
                        line_length_next = line_length_reg + LEN_W'(1);
                        cr_next = (rx_byte == CHAR_CR);
                        m_idle_next = m_idle_reg && line_length_reg < IDLE_LEN
                            && rx_byte == word_byte(IDLE_WORD, line_length_reg[2:0]);
                        m_active_next = m_active_reg && line_length_reg < ACTIVE_LEN
                            && rx_byte == word_byte(ACTIVE_WORD, line_length_reg[2:0]);
                        m_alarm_next = m_alarm_reg && line_length_reg < ALARM_LEN
                            && rx_byte == word_byte(ALARM_WORD, line_length_reg[2:0]);
                        pend_valid_next = 1'b1;
                        if (m_idle_reg && line_length_reg == IDLE_LEN)
                        begin
                            pend_mode_next = MODE_IDLE;
                        end
                        else if (m_active_reg && line_length_reg == ACTIVE_LEN)
                        begin
                            pend_mode_next = MODE_ACTIVE;
                        end
                        else if (m_alarm_reg && line_length_reg == ALARM_LEN)
                        begin
                            pend_mode_next = MODE_ALARM;
                        end
                        else
                        begin
                            pend_valid_next = 1'b0;
                        end
                    end
                end
            end
            else
            begin
                if (heartbeat_reg != 16'hFFFF)
                begin
                    heartbeat_next = heartbeat_reg + 16'd1;
                end
                if (blink_inc >= {1'b0, blink_period_reg})
                begin
                    blink_next = '0;
                    alarm_next = '0;
                end
                else
                begin
                    blink_next = blink_inc[15:0];
                    alarm_next = (alarm_inc >= {1'b0, alarm_period_reg}) ?
                        16'd0 : alarm_inc[15:0];
                end
            end

            if (heartbeat_next >= timeout_reg)
            begin
                mode_next = MODE_DISCONNECTED;
            end

            blink_on = blink_next < (blink_period_reg >> 1);
            res.mode_now = mode_next;
            unique case (mode_next)
                MODE_DISCONNECTED: res.red_on = blink_on;
                MODE_IDLE:         res.green_on = 1'b1;
                MODE_ACTIVE:       res.green_on = blink_on;
                MODE_ALARM:
                begin
                    res.buzzer_enable = blink_on;
                    res.red_on = blink_on && (alarm_next < (alarm_period_reg >> 1));
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next = out_reg;
        skid_next = skid_reg;
        if (accept)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_next = res;
                skid_valid_next = 1'b1;
            end
            else
            begin
                out_next = res;
                out_valid_next = 1'b1;
            end
        end
        else if (out_take)
        begin
            if (skid_valid_reg)
            begin
                out_next = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= HEARTBEAT_TIMEOUT_RESET;
            blink_period_reg <= BLINK_PERIOD_RESET;
            alarm_period_reg <= ALARM_PERIOD_RESET;
            line_length_reg <= '0;
            skip_reg <= '0;
            cr_reg <= 1'b0;
            m_idle_reg <= 1'b1;
            m_active_reg <= 1'b1;
            m_alarm_reg <= 1'b1;
            pend_valid_reg <= 1'b0;
            mode_reg <= MODE_DISCONNECTED;
            heartbeat_reg <= '0;
            blink_reg <= '0;
            alarm_reg <= '0;
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            timeout_reg <= timeout_next;
            blink_period_reg <= blink_period_next;
            alarm_period_reg <= alarm_period_next;
            line_length_reg <= line_length_next;
            skip_reg <= skip_next;
            cr_reg <= cr_next;
            m_idle_reg <= m_idle_next;
            m_active_reg <= m_active_next;
            m_alarm_reg <= m_alarm_next;
            pend_valid_reg <= pend_valid_next;
            mode_reg <= mode_next;
            heartbeat_reg <= heartbeat_next;
            blink_reg <= blink_next;
            alarm_reg <= alarm_next;
            out_valid_reg <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_mode_reg <= pend_mode_next;
        out_reg <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid = out_valid_reg;
    assign green_on = out_reg.green_on;
    assign red_on = out_reg.red_on;
    assign buzzer_enable = out_reg.buzzer_enable;
    assign mode_now = out_reg.mode_now;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("second buffer entry held without a presented result");

    a_line_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        line_length_reg <= LEN_W'(LINE_CAPACITY))
        else $error("line length beyond capacity");

    a_cr_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        cr_reg |-> line_length_reg != '0)
        else $error("carriage return flag set on an empty line");

    a_request_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("accepted request produced no result");

endmodule
